// ----- rtl/core/dtc_pkg.sv -----
// ----------------------------------------------------------------------------
// dtc_pkg: shared types and constants for the divider/timer counter
// Holds the request and result layouts, the operation codes and the
// register indexes used by the core, the top level and the checker.
// ----------------------------------------------------------------------------
package dtc_pkg;

  localparam int unsigned DIV_W    = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CTRL_W   = 3;
  localparam int unsigned DLY_W    = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 1;

  // Reload: overflow sets delay; midpoint (count zero) and end load modulo.
  localparam logic [DLY_W-1:0] DLY_START = 4'd8;
  localparam logic [DLY_W-1:0] DLY_MID   = 4'd4;

  // Frame-step divider taps.
  localparam int unsigned FRAME_BIT_NORMAL = 12;
  localparam int unsigned FRAME_BIT_DOUBLE = 13;

  // Packed widths on the stream ports (padded to whole bytes).
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_WR_COUNT  = 2'd1,
    OP_WR_MODULO = 2'd2,
    OP_WR_CTRL   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOUBLE_SPEED = 1'd0,
    CFG_FRAME_ENABLE = 1'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] write_data;
    op_t               operation;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] divider_high;
    logic              frame_step;
    logic              timer_irq;
    logic [BYTE_W-1:0] counter_out;
  } res_t;

  // Control bits 1:0 pick the divider tap, bit 2 gates it.
  function automatic logic timer_tap(input logic [CTRL_W-1:0] ctrl,
                                     input logic [DIV_W-1:0] div);
    logic b;
    case (ctrl[1:0])
      2'd0:    b = div[9];
      2'd1:    b = div[3];
      2'd2:    b = div[5];
      default: b = div[7];
    endcase
    return b & ctrl[2];
  endfunction

endpackage

// ----- rtl/core/dtc_core.sv -----
// ----------------------------------------------------------------------------
// dtc_core: timer state and single-pass update logic
// Holds the divider, counter, modulo, control, reload delay and edge flags,
// and computes one result and the next state for each advancing request.
// ----------------------------------------------------------------------------
module dtc_core import dtc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  req_t                  req,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output res_t                  res
);

  logic [DIV_W-1:0]  div_r,  div_nxt;
  logic [BYTE_W-1:0] cnt_r,  cnt_nxt;
  logic [BYTE_W-1:0] mod_r,  mod_nxt;
  logic [CTRL_W-1:0] ctrl_r, ctrl_nxt;
  logic [DLY_W-1:0]  dly_r,  dly_nxt;
  logic              tedge_r, tedge_nxt;
  logic              fedge_r, fedge_nxt;
  logic              dspeed_r, fenable_r;

  logic [DIV_W-1:0]  div_inc;
  logic              tcur, fcur, inc, irq, fstep;
  logic [BYTE_W-1:0] cnt_inc;
  logic [DLY_W-1:0]  dly_ld, dly_dec;

  always_comb begin
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    mod_nxt   = mod_r;
    ctrl_nxt  = ctrl_r;
    dly_nxt   = dly_r;
    tedge_nxt = tedge_r;
    fedge_nxt = fedge_r;
    irq       = 1'b0;
    fstep     = 1'b0;

    div_inc = div_r + 16'd1;
    tcur    = timer_tap(ctrl_r, div_inc);
    inc     = tedge_r & ~tcur;
    cnt_inc = inc ? cnt_r + 8'd1 : cnt_r;
    dly_ld  = (inc && cnt_r == 8'hFF) ? DLY_START : dly_r;
    dly_dec = dly_ld - 4'd1;
    fcur    = dspeed_r ? div_inc[FRAME_BIT_DOUBLE] : div_inc[FRAME_BIT_NORMAL];

    case (req.operation)
      OP_WR_COUNT:  cnt_nxt  = req.write_data;
      OP_WR_MODULO: mod_nxt  = req.write_data;
      OP_WR_CTRL:   ctrl_nxt = req.write_data[CTRL_W-1:0];
      OP_TICK: begin
        div_nxt   = div_inc;
        tedge_nxt = tcur;
        cnt_nxt   = cnt_inc;
        dly_nxt   = dly_ld;
        if (dly_ld != '0) begin
          dly_nxt = dly_dec;
          if (dly_dec == DLY_MID) begin
            // A nonzero counter at the midpoint cancels the whole reload.
            if (cnt_inc != '0) begin
              dly_nxt = '0;
            end else begin
              cnt_nxt = mod_r;
              irq     = 1'b1;
            end
          end else if (dly_dec == '0) begin
            cnt_nxt = mod_r;
          end
        end
        if (fenable_r) begin
          fstep     = fedge_r & ~fcur;
          fedge_nxt = fcur;
        end
      end
      default: ;
    endcase
  end

  assign res.counter_out  = cnt_nxt;
  assign res.timer_irq    = irq;
  assign res.frame_step   = fstep;
  assign res.divider_high = div_nxt[DIV_W-1 -: BYTE_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r   <= '0;
      cnt_r   <= '0;
      mod_r   <= '0;
      ctrl_r  <= '0;
      dly_r   <= '0;
      tedge_r <= 1'b0;
      fedge_r <= 1'b0;
    end else if (adv) begin
      div_r   <= div_nxt;
      cnt_r   <= cnt_nxt;
      mod_r   <= mod_nxt;
      ctrl_r  <= ctrl_nxt;
      dly_r   <= dly_nxt;
      tedge_r <= tedge_nxt;
      fedge_r <= fedge_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dspeed_r  <= 1'b0;
      fenable_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_DOUBLE_SPEED: dspeed_r  <= cfg_data[0];
        CFG_FRAME_ENABLE: fenable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/divider_timer_counter_unit.sv -----
// ----------------------------------------------------------------------------
// divider_timer_counter_unit: divider, timer counter and frame-step unit
// Takes tick and register-write requests, one per cycle while results flow, and
// returns one result per request with the counter, interrupt pulse and divider byte.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  in_*      slave      tvalid / tready    operation, write_data
//  out_*     master     tvalid / tready    counter, irq, frame step, divider
//  cfg_*     write      cfg_we             speed select, frame_enable
//
// A request is held in the input register and then moves to the result register,
// from which its result is offered, and the unit sustains one request per clock
// while the result side is not stalled. The core updates the
// timer state as a request moves across, so back-to-back requests see each other.
// Reset (synchronous, rst_n low) empties both registers and clears the state,
// with frame_enable set. A stalled result holds, the input fills, in_tready drops.
//
module divider_timer_counter_unit import dtc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] operation, [9:2] write_data, [15:10] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] counter_out, [8] timer_irq, [9] frame_step, [17:10] divider_high,
  // [23:18] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned REQ_W = $bits(req_t);
  localparam int unsigned RES_W = $bits(res_t);

  logic in_valid_r;
  req_t in_req_r;
  logic out_valid_r;
  res_t out_res_r;
  res_t res;
  logic adv;

  // The input register moves on whenever the result register is free or is
  // being emptied this cycle.
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_req_r <= req_t'(in_tdata[REQ_W-1:0]);
    end
  end

  dtc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .req      (in_req_r),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_wdata),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, out_res_r};

endmodule

// ----- rtl/core/dtc_checker.sv -----
// ----------------------------------------------------------------------------
// dtc_checker: port-level checks for the divider/timer counter unit
// Watches the stream ports and flags handshake and interrupt-spacing slips.
// ----------------------------------------------------------------------------
module dtc_checker import dtc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // A held result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // With the result register empty, the input side can never be blocked.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("request refused with empty output");

  // An accepted interrupt result is never directly followed by another one.
  a_irq_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata[8] |=> !(out_tvalid && out_tdata[8]))
    else $error("timer interrupt on consecutive results");

endmodule

bind divider_timer_counter_unit dtc_checker u_dtc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
